@@ rtl/nearest_segment_search_core_defines.svh @@
// Assertion macros shared by the RTL.
`ifndef NEAREST_SEGMENT_SEARCH_CORE_DEFINES_SVH
`define NEAREST_SEGMENT_SEARCH_CORE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define NSS_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("nearest segment search: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define NSS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("nearest segment search: next-cycle check failed");

`endif

@@ rtl/nss_pkg.sv @@
package nss_pkg;

  localparam int COORD_W  = 16;
  localparam int AXIS_W   = COORD_W + 1;
  localparam int T_FRAC   = 16;
  localparam int T_W      = T_FRAC + 1;
  localparam int MUL_W    = 18;
  localparam int PROD_W   = 2 * MUL_W;
  localparam int LEN2_W   = 34;
  localparam int DOT_W    = 35;
  localparam int DIFF_W   = 18;
  localparam int DIST_W   = 36;
  localparam int OUT_D_W  = 34;
  localparam int IDX_PORT_W = 6;
  localparam int CNT_CFG_W  = 7;
  localparam int DIV_CNT_W  = $clog2(T_FRAC);
  localparam int WIDE_IDX_W = 11;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef struct packed {
    logic                       op;
    logic [IDX_PORT_W-1:0]      seg_index;
    logic signed [COORD_W-1:0]  head_x;
    logic signed [COORD_W-1:0]  head_y;
    logic signed [COORD_W-1:0]  head_z;
    logic signed [COORD_W-1:0]  tail_x;
    logic signed [COORD_W-1:0]  tail_y;
    logic signed [COORD_W-1:0]  tail_z;
    logic signed [COORD_W-1:0]  point_x;
    logic signed [COORD_W-1:0]  point_y;
    logic signed [COORD_W-1:0]  point_z;
  } query_t;

  typedef struct packed {
    logic [IDX_PORT_W-1:0] nearest_index;
    logic [OUT_D_W-1:0]    distance_squared;
    logic                  empty_flag;
  } result_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] head_x;
    logic signed [COORD_W-1:0] head_y;
    logic signed [COORD_W-1:0] head_z;
    logic signed [COORD_W-1:0] tail_x;
    logic signed [COORD_W-1:0] tail_y;
    logic signed [COORD_W-1:0] tail_z;
  } seg_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
  } point_t;

  typedef struct packed {
    logic              done;
    logic [DIST_W-1:0] dist_sq;
  } eng_status_t;

endpackage

@@ rtl/nss_ram.sv @@
module nss_ram #(
  parameter int WIDTH = 96,
  parameter int DEPTH = 64
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/nss_div.sv @@
module nss_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [nss_pkg::LEN2_W-1:0]  dividend,
  input  logic [nss_pkg::LEN2_W-1:0]  divisor,
  output logic                        done,
  output logic [nss_pkg::T_FRAC-1:0]  quotient
);

  logic                          busy;
  logic [nss_pkg::DIV_CNT_W-1:0] cnt;
  logic [nss_pkg::LEN2_W-1:0]    rem;
  logic [nss_pkg::LEN2_W-1:0]    dsr;
  logic [nss_pkg::LEN2_W:0]      rem2;
  logic [nss_pkg::LEN2_W:0]      diff;
  logic                          qbit;

  // dividend < divisor, so each step's remainder stays below the divisor
  assign rem2 = {rem, 1'b0};
  assign diff = rem2 - {1'b0, dsr};
  assign qbit = (rem2 >= {1'b0, dsr});

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy     <= 1'b1;
      cnt      <= '0;
      rem      <= dividend;
      dsr      <= divisor;
      quotient <= '0;
    end else if (busy) begin
      rem      <= qbit ? diff[nss_pkg::LEN2_W-1:0] : rem2[nss_pkg::LEN2_W-1:0];
      quotient <= {quotient[nss_pkg::T_FRAC-2:0], qbit};
      cnt      <= cnt + 1'b1;
      if (cnt == nss_pkg::DIV_CNT_W'(nss_pkg::T_FRAC - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

endmodule

@@ rtl/nss_eng.sv @@
module nss_eng (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  nss_pkg::seg_t        seg,
  input  nss_pkg::point_t      point,
  output nss_pkg::eng_status_t status
);

  typedef enum logic [2:0] {E_IDLE, E_DOT, E_CLASS, E_DIV, E_OFF, E_SQ} state_t;

  localparam int AW = nss_pkg::AXIS_W;
  localparam int MW = nss_pkg::MUL_W;
  localparam int RW = 20;

  state_t state;
  logic [2:0] step;

  logic signed [AW-1:0] ax, ay, az, rx, ry, rz;
  logic signed [nss_pkg::DIFF_W-1:0] dx, dy, dz;
  logic [nss_pkg::LEN2_W-1:0] len2;
  logic signed [nss_pkg::DOT_W-1:0] dot;
  logic [nss_pkg::T_W-1:0] t;
  logic [nss_pkg::DIST_W-1:0] sum;
  logic signed [nss_pkg::PROD_W-1:0] prod;

  logic signed [MW-1:0] mul_a, mul_b;
  logic signed [AW-1:0] rel_sel;
  logic                 neg;
  logic [nss_pkg::PROD_W-1:0] mag;
  logic [nss_pkg::PROD_W-1:0] rnd;
  logic signed [RW-1:0] off;
  logic signed [RW-1:0] dnew;
  logic [nss_pkg::DIST_W-1:0] sum_next;

  logic div_start, div_done;
  logic [nss_pkg::T_FRAC-1:0] quot;

  nss_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (dot[nss_pkg::LEN2_W-1:0]),
    .divisor  (len2),
    .done     (div_done),
    .quotient (quot)
  );

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (state == E_DOT) begin
      unique case (step)
        3'd0: begin mul_a = MW'(ax); mul_b = MW'(ax); end
        3'd1: begin mul_a = MW'(ay); mul_b = MW'(ay); end
        3'd2: begin mul_a = MW'(az); mul_b = MW'(az); end
        3'd3: begin mul_a = MW'(rx); mul_b = MW'(ax); end
        3'd4: begin mul_a = MW'(ry); mul_b = MW'(ay); end
        3'd5: begin mul_a = MW'(rz); mul_b = MW'(az); end
        default: begin mul_a = '0; mul_b = '0; end
      endcase
    end else if (state == E_OFF) begin
      mul_a = $signed({1'b0, t});
      unique case (step)
        3'd0: mul_b = MW'(ax);
        3'd1: mul_b = MW'(ay);
        3'd2: mul_b = MW'(az);
        default: mul_b = '0;
      endcase
    end else if (state == E_SQ) begin
      unique case (step)
        3'd0: begin mul_a = dx; mul_b = dx; end
        3'd1: begin mul_a = dy; mul_b = dy; end
        3'd2: begin mul_a = dz; mul_b = dz; end
        default: begin mul_a = '0; mul_b = '0; end
      endcase
    end
  end

  always_comb begin
    unique case (step)
      3'd1:    rel_sel = rx;
      3'd2:    rel_sel = ry;
      default: rel_sel = rz;
    endcase
    neg  = prod[nss_pkg::PROD_W-1];
    mag  = neg ? nss_pkg::PROD_W'(-prod) : nss_pkg::PROD_W'(prod);
    rnd  = (mag + nss_pkg::PROD_W'(1 << (nss_pkg::T_FRAC - 1))) >> nss_pkg::T_FRAC;
    off  = neg ? -$signed(rnd[RW-1:0]) : $signed(rnd[RW-1:0]);
    dnew = RW'(rel_sel) - off;
    sum_next = sum + nss_pkg::DIST_W'(prod[nss_pkg::PROD_W-2:0]);
  end

  assign div_start = (state == E_CLASS) && (len2 != '0) && !dot[nss_pkg::DOT_W-1]
                     && (dot != '0) && (dot[nss_pkg::LEN2_W-1:0] < len2);

  always_ff @(posedge clk) begin
    prod        <= mul_a * mul_b;
    status.done <= 1'b0;
    if (rst) begin
      state <= E_IDLE;
      step  <= '0;
    end else begin
      unique case (state)
        E_IDLE: begin
          if (start) begin
            ax   <= AW'(seg.tail_x) - AW'(seg.head_x);
            ay   <= AW'(seg.tail_y) - AW'(seg.head_y);
            az   <= AW'(seg.tail_z) - AW'(seg.head_z);
            rx   <= AW'(point.x) - AW'(seg.head_x);
            ry   <= AW'(point.y) - AW'(seg.head_y);
            rz   <= AW'(point.z) - AW'(seg.head_z);
            len2 <= '0;
            dot  <= '0;
            step <= '0;
            state <= E_DOT;
          end
        end
        E_DOT: begin
          step <= step + 1'b1;
          if (step >= 3'd1 && step <= 3'd3) begin
            len2 <= len2 + prod[nss_pkg::LEN2_W-1:0];
          end else if (step >= 3'd4) begin
            dot <= dot + $signed(prod[nss_pkg::DOT_W-1:0]);
          end
          if (step == 3'd6) begin
            state <= E_CLASS;
          end
        end
        E_CLASS: begin
          step <= '0;
          if (len2 == '0 || dot[nss_pkg::DOT_W-1] || dot == '0) begin
            t     <= '0;
            state <= E_OFF;
          end else if (!div_start) begin
            t     <= nss_pkg::T_W'(1 << nss_pkg::T_FRAC);
            state <= E_OFF;
          end else begin
            state <= E_DIV;
          end
        end
        E_DIV: begin
          if (div_done) begin
            t     <= {1'b0, quot};
            step  <= '0;
            state <= E_OFF;
          end
        end
        E_OFF: begin
          step <= step + 1'b1;
          unique case (step)
            3'd1: dx <= dnew[nss_pkg::DIFF_W-1:0];
            3'd2: dy <= dnew[nss_pkg::DIFF_W-1:0];
            3'd3: dz <= dnew[nss_pkg::DIFF_W-1:0];
            default: ;
          endcase
          if (step == 3'd3) begin
            step  <= '0;
            sum   <= '0;
            state <= E_SQ;
          end
        end
        E_SQ: begin
          step <= step + 1'b1;
          if (step != 3'd0) begin
            sum <= sum_next;
          end
          if (step == 3'd3) begin
            status.dist_sq <= sum_next;
            status.done    <= 1'b1;
            state          <= E_IDLE;
          end
        end
        default: state <= E_IDLE;
      endcase
    end
  end

endmodule

@@ rtl/nearest_segment_search_core.sv @@
// Nearest 3D segment search. A load item (op 0) writes one segment entry and
// leaves the block idle. A query item (op 1) scans entries 0 to
// segment_count-1 (clamped to MAX_SEGMENTS) one after another through a
// single shared 18x18 multiplier and a 16-step restoring divider; an entry
// takes longer when the projection falls inside the segment and needs the
// divide. An empty table answers with empty_flag set. The block takes no new
// item while a query is in progress; a finished result waits in an output
// register. segment_count is written through cfg_we/cfg_data and must only
// change while the block is idle.
`include "nearest_segment_search_core_defines.svh"

module nearest_segment_search_core #(
  parameter int MAX_SEGMENTS = 64
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               query_valid,
  output logic                               query_stall,
  input  nss_pkg::query_t                    query,
  output logic                               result_valid,
  input  logic                               result_stall,
  output nss_pkg::result_t                   result,
  input  logic                               cfg_we,
  input  logic [nss_pkg::CNT_CFG_W-1:0]      cfg_data
);

  localparam int IDX_W = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
  localparam int CNT_W = $clog2(MAX_SEGMENTS + 1);
  localparam int WW    = nss_pkg::WIDE_IDX_W;

  typedef enum logic [2:0] {S_IDLE, S_READ, S_LOAD, S_EVAL, S_DONE} state_t;

  state_t state;
  logic [nss_pkg::CNT_CFG_W-1:0] seg_count;
  logic [CNT_W-1:0]              idx;
  logic [CNT_W-1:0]              n_eff;
  logic [IDX_W-1:0]              best_idx;
  logic [nss_pkg::DIST_W-1:0]    best_d;
  logic                          empty;
  nss_pkg::point_t               point;
  nss_pkg::seg_t                 rd_seg;
  nss_pkg::seg_t                 wr_seg;
  nss_pkg::eng_status_t          eng_st;
  logic                          accept, load_we, out_free;
  logic [WW-1:0]                 wide_sidx;
  logic [WW-1:0]                 wide_best;

  assign accept    = query_valid && !query_stall;
  assign wide_sidx = WW'(query.seg_index);
  assign load_we   = accept && (query.op == nss_pkg::OP_LOAD)
                     && (wide_sidx < WW'(MAX_SEGMENTS));
  assign n_eff     = (WW'(seg_count) > WW'(MAX_SEGMENTS)) ? CNT_W'(MAX_SEGMENTS)
                                                          : CNT_W'(seg_count);
  assign out_free  = !result_valid || !result_stall;
  assign query_stall = (state != S_IDLE);
  assign wide_best = WW'(best_idx);

  assign wr_seg = '{head_x: query.head_x, head_y: query.head_y, head_z: query.head_z,
                    tail_x: query.tail_x, tail_y: query.tail_y, tail_z: query.tail_z};

  nss_ram #(
    .WIDTH ($bits(nss_pkg::seg_t)),
    .DEPTH (MAX_SEGMENTS)
  ) u_store (
    .clk   (clk),
    .we    (load_we),
    .waddr (wide_sidx[IDX_W-1:0]),
    .wdata (wr_seg),
    .re    (state == S_READ),
    .raddr (idx[IDX_W-1:0]),
    .rdata (rd_seg)
  );

  nss_eng u_eng (
    .clk    (clk),
    .rst    (rst),
    .start  (state == S_LOAD),
    .seg    (rd_seg),
    .point  (point),
    .status (eng_st)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      seg_count    <= '0;
      result_valid <= 1'b0;
      idx          <= '0;
    end else begin
      if (cfg_we) begin
        seg_count <= cfg_data;
      end
      if (result_valid && !result_stall && state != S_DONE) begin
        result_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept && query.op == nss_pkg::OP_QUERY) begin
            point <= '{x: query.point_x, y: query.point_y, z: query.point_z};
            idx   <= '0;
            if (n_eff == '0) begin
              empty    <= 1'b1;
              best_idx <= '0;
              best_d   <= '0;
              state    <= S_DONE;
            end else begin
              empty <= 1'b0;
              state <= S_READ;
            end
          end
        end
        S_READ: state <= S_LOAD;
        S_LOAD: state <= S_EVAL;
        S_EVAL: begin
          if (eng_st.done) begin
            if (idx == '0 || eng_st.dist_sq < best_d) begin
              best_d   <= eng_st.dist_sq;
              best_idx <= idx[IDX_W-1:0];
            end
            if (idx + 1'b1 == n_eff) begin
              state <= S_DONE;
            end else begin
              idx   <= idx + 1'b1;
              state <= S_READ;
            end
          end
        end
        S_DONE: begin
          if (out_free) begin
            result.nearest_index    <= wide_best[nss_pkg::IDX_PORT_W-1:0];
            result.distance_squared <= best_d[nss_pkg::OUT_D_W-1:0];
            result.empty_flag       <= empty;
            result_valid            <= 1'b1;
            state                   <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `NSS_ASSERT_NOW(a_done_in_eval, clk, rst, eng_st.done, state == S_EVAL)
  `NSS_ASSERT_NEXT(a_query_starts, clk, rst,
                   accept && query.op == nss_pkg::OP_QUERY && n_eff != '0,
                   state == S_READ)
  `NSS_ASSERT_NEXT(a_load_no_busy, clk, rst,
                   accept && query.op == nss_pkg::OP_LOAD, state == S_IDLE)
  `NSS_ASSERT_NOW(a_idx_in_range, clk, rst, state == S_EVAL, idx < n_eff)

endmodule

@@ verif/tb_nearest_segment_search_core.sv @@
module tb_nearest_segment_search_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_SEGS = 64;
  localparam int WATCHDOG_LIMIT = 40000;
  localparam int SETTLE_CYCLES = 8;

  class nearest_scoreboard;
    nss_pkg::seg_t    seg_table[NUM_SEGS];
    bit [6:0]         active_count;
    nss_pkg::result_t pending_q[$];
    int               errors;
    int               n_loads, n_queries, n_empty, n_results;

    function void set_count(bit [6:0] v);
      active_count = v;
    endfunction

    function longint unsigned seg_dist(nss_pkg::point_t p, nss_pkg::seg_t s);
      longint ax[3], rl[3], len2, dot, t, prod, off, d, r;
      longint unsigned sum;
      ax[0] = longint'(s.tail_x) - longint'(s.head_x);
      ax[1] = longint'(s.tail_y) - longint'(s.head_y);
      ax[2] = longint'(s.tail_z) - longint'(s.head_z);
      rl[0] = longint'(p.x) - longint'(s.head_x);
      rl[1] = longint'(p.y) - longint'(s.head_y);
      rl[2] = longint'(p.z) - longint'(s.head_z);
      len2 = 0;
      dot = 0;
      sum = 0;
      for (int c = 0; c < 3; c++) begin
        len2 += ax[c] * ax[c];
        dot += rl[c] * ax[c];
      end
      if (len2 <= 0 || dot <= 0) t = 0;
      else if (dot >= len2) t = longint'(1) << nss_pkg::T_FRAC;
      else t = (dot << nss_pkg::T_FRAC) / len2;
      for (int c = 0; c < 3; c++) begin
        prod = t * ax[c];
        r = ((prod < 0 ? -prod : prod) + (longint'(1) << (nss_pkg::T_FRAC - 1)))
            >>> nss_pkg::T_FRAC;
        off = prod < 0 ? -r : r;
        d = rl[c] - off;
        if (d < 0) d = -d;
        sum += longint'(d) * longint'(d);
      end
      return sum;
    endfunction

    function void note_item(nss_pkg::query_t q);
      int n;
      nss_pkg::point_t p;
      longint unsigned best_d, dd;
      nss_pkg::result_t e;
      if (q.op == nss_pkg::OP_LOAD) begin
        seg_table[q.seg_index] = '{q.head_x, q.head_y, q.head_z,
                                   q.tail_x, q.tail_y, q.tail_z};
        n_loads++;
        return;
      end
      n_queries++;
      n = active_count > NUM_SEGS ? NUM_SEGS : active_count;
      e = '0;
      if (n == 0) begin
        e.empty_flag = 1'b1;
        n_empty++;
      end else begin
        p = '{q.point_x, q.point_y, q.point_z};
        best_d = seg_dist(p, seg_table[0]);
        for (int i = 1; i < n; i++) begin
          dd = seg_dist(p, seg_table[i]);
          if (dd < best_d) begin
            best_d = dd;
            e.nearest_index = i[5:0];
          end
        end
        e.distance_squared = best_d[nss_pkg::OUT_D_W-1:0];
      end
      pending_q = {pending_q, e};
    endfunction

    function void check_result(nss_pkg::result_t r);
      nss_pkg::result_t e;
      if (pending_q.size() == 0) begin
        $error("unexpected result: index %0d dist %0d empty %0b",
               r.nearest_index, r.distance_squared, r.empty_flag);
        errors++;
        return;
      end
      e = pending_q.pop_front();
      n_results++;
      if (r.nearest_index !== e.nearest_index) begin
        $error("nearest_index: expected %0d actual %0d", e.nearest_index, r.nearest_index);
        errors++;
      end
      if (r.distance_squared !== e.distance_squared) begin
        $error("distance_squared: expected %0d actual %0d",
               e.distance_squared, r.distance_squared);
        errors++;
      end
      if (r.empty_flag !== e.empty_flag) begin
        $error("empty_flag: expected %0b actual %0b", e.empty_flag, r.empty_flag);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic query_valid = 1'b0;
  logic query_stall;
  nss_pkg::query_t query = '0;
  logic result_valid;
  logic result_stall = 1'b0;
  nss_pkg::result_t result;
  logic cfg_we = 1'b0;
  logic [nss_pkg::CNT_CFG_W-1:0] cfg_data = '0;

  nearest_scoreboard sb;
  bit no_idle = 1'b0;
  bit [NUM_SEGS-1:0] loaded = '0;
  int idle_cycles = 0;
  int n_settings = 0;

  nearest_segment_search_core dut (
    .clk(clk), .rst(rst),
    .query_valid(query_valid), .query_stall(query_stall), .query(query),
    .result_valid(result_valid), .result_stall(result_stall), .result(result),
    .cfg_we(cfg_we), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  always @(negedge clk) result_stall <= !no_idle && ($urandom_range(99) < 38);

  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) sb.check_result(result);
  end

  always @(posedge clk) begin
    if (rst || (query_valid && !query_stall) || (result_valid && !result_stall))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog expired after %0d quiet cycles", idle_cycles);
      $display("** nearest_segment_search_core: FAILED **");
      $finish;
    end
  end

  // entered and left at a falling edge
  task automatic send_item(nss_pkg::query_t q);
    while (!no_idle && $urandom_range(99) < 38) begin
      query_valid <= 1'b0;
      @(negedge clk);
    end
    query <= q;
    query_valid <= 1'b1;
    do @(posedge clk); while (query_stall);
    sb.note_item(q);
    if (q.op == nss_pkg::OP_LOAD) loaded[q.seg_index] = 1'b1;
    @(negedge clk);
  endtask

  task automatic drain();
    query_valid <= 1'b0;
    while (sb.pending_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic set_count(bit [6:0] v);
    drain();
    cfg_we <= 1'b1;
    cfg_data <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    sb.set_count(v);
    n_settings++;
  endtask

  function automatic logic signed [15:0] rnd_coord();
    case ($urandom_range(3))
      0: return 16'($urandom);
      1: return 16'($urandom_range(1023)) - 16'sd512;
      2: return $urandom_range(1) ? 16'sh7fff : 16'sh8000;
      default: return 16'($urandom_range(255)) - 16'sd128;
    endcase
  endfunction

  function automatic nss_pkg::query_t load_item(bit [5:0] idx,
                                                logic signed [15:0] hx, hy, hz,
                                                tx, ty, tz);
    nss_pkg::query_t q;
    q = '0;
    q.op = nss_pkg::OP_LOAD;
    q.seg_index = idx;
    q.head_x = hx; q.head_y = hy; q.head_z = hz;
    q.tail_x = tx; q.tail_y = ty; q.tail_z = tz;
    q.point_x = 16'($urandom); q.point_y = 16'($urandom); q.point_z = 16'($urandom);
    return q;
  endfunction

  function automatic nss_pkg::query_t rnd_load(bit [5:0] idx);
    nss_pkg::query_t q;
    q = load_item(idx, rnd_coord(), rnd_coord(), rnd_coord(),
                  rnd_coord(), rnd_coord(), rnd_coord());
    if ($urandom_range(7) == 0) begin
      q.tail_x = q.head_x; q.tail_y = q.head_y; q.tail_z = q.head_z;
    end
    return q;
  endfunction

  function automatic nss_pkg::query_t query_item(logic signed [15:0] px, py, pz);
    nss_pkg::query_t q;
    q = '0;
    q.op = nss_pkg::OP_QUERY;
    q.seg_index = 6'($urandom);
    q.head_x = 16'($urandom); q.head_y = 16'($urandom); q.head_z = 16'($urandom);
    q.tail_x = 16'($urandom); q.tail_y = 16'($urandom); q.tail_z = 16'($urandom);
    q.point_x = px; q.point_y = py; q.point_z = pz;
    return q;
  endfunction

  function automatic int written_prefix();
    int n;
    n = 0;
    while (n < NUM_SEGS && loaded[n]) n++;
    return n;
  endfunction

  initial begin
    int items, prefix, burst_len;
    bit [6:0] cnt;
    sb = new();
    items = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed
    set_count(7'd0);
    send_item(query_item(16'sh7fff, 16'sh8000, 16'sh0000));
    send_item(load_item(6'd0, 16'sh7fff, 16'sh7fff, 16'sh7fff,
                        16'sh7fff, 16'sh7fff, 16'sh7fff));
    send_item(load_item(6'd1, 16'sh8000, 16'sh8000, 16'sh8000,
                        16'sh7fff, 16'sh7fff, 16'sh7fff));
    send_item(load_item(6'd2, 16'sh8000, 16'sh8000, 16'sh8000,
                        16'sh7fff, 16'sh7fff, 16'sh7fff));
    send_item(load_item(6'd3, 16'sh0000, 16'sh0000, 16'sh0000,
                        16'sh0100, 16'sh0000, 16'sh0000));
    set_count(7'd4);
    send_item(query_item(16'sh7fff, 16'sh7fff, 16'sh7fff));
    send_item(query_item(16'sh8000, 16'sh8000, 16'sh8000));
    send_item(query_item(16'sh0000, 16'sh0000, 16'sh0000));
    send_item(query_item(16'sh0300, 16'sh0000, 16'sh0000));
    send_item(query_item(-16'sh0300, 16'sh0000, 16'sh0000));
    send_item(query_item(16'sh0080, 16'sh0040, -16'sh0040));
    send_item(query_item(16'sh7fff, 16'sh8000, 16'sh7fff));
    set_count(7'd1);
    send_item(query_item(16'sh8000, 16'sh7fff, 16'sh8000));
    items = 13;

    // fill the table
    for (int i = 0; i < NUM_SEGS; i++) begin
      send_item(rnd_load(i[5:0]));
      items++;
    end
    set_count(7'd127);
    send_item(query_item(rnd_coord(), rnd_coord(), rnd_coord()));
    send_item(query_item(rnd_coord(), rnd_coord(), rnd_coord()));
    items += 2;

    for (int ph = 0; items < 460; ph++) begin
      no_idle = (ph == 3);
      prefix = written_prefix();
      case ($urandom_range(9))
        0: cnt = 7'd0;
        1: cnt = 7'($urandom_range(127, 64));
        default: cnt = 7'($urandom_range(12, 1));
      endcase
      if (cnt > prefix) cnt = 7'(prefix);
      set_count(cnt);
      burst_len = (cnt >= 32) ? 4 : $urandom_range(20, 10);
      for (int k = 0; k < burst_len; k++) begin
        if (k == burst_len / 2 && ph % 4 == 1) drain();
        if ($urandom_range(3) == 0) send_item(rnd_load(6'($urandom)));
        else send_item(query_item(rnd_coord(), rnd_coord(), rnd_coord()));
        items++;
      end
    end
    no_idle = 1'b0;

    drain();
    repeat (50) @(negedge clk);
    if (sb.pending_q.size() != 0) begin
      $error("%0d results never arrived", sb.pending_q.size());
      sb.errors++;
    end
    $display("covered %0d loads and %0d queries (%0d on an empty table), %0d counts",
             sb.n_loads, sb.n_queries, sb.n_empty, n_settings);
    $display("checked %0d results, %0d mismatches", sb.n_results, sb.errors);
    if (sb.errors == 0)
      $display("** nearest_segment_search_core: PASSED **");
    else
      $display("** nearest_segment_search_core: FAILED **");
    $finish;
  end
endmodule
